// ===== hdl/uis_pkg.sv =====
// uis_pkg: shared types and constants for the unique item set.
// No dependencies; imported by uis_scan and unique_item_set.
`default_nettype none

package uis_pkg;

    localparam int unsigned VALUE_W = 32;  // item_value field width
    localparam int unsigned COUNT_W = 5;   // item_count field width
    localparam int unsigned RES_W   = 8;   // packed result beat width

    typedef struct packed {
        logic [COUNT_W-1:0] item_count;
        logic               full_reject;
        logic               stored_now;
        logic               was_present;
    } res_t;

endpackage

`default_nettype wire

// ===== hdl/uis_scan.sv =====
// uis_scan: slot memory, occupancy count and the compare-scan sequencer.
// Depends on uis_pkg.
`default_nettype none

module uis_scan
    import uis_pkg::*;
#(
    parameter int unsigned SET_DEPTH  = 16,
    parameter int unsigned ITEM_WIDTH = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               in_action,
    input  wire logic [VALUE_W-1:0] in_value,
    output logic                    res_valid,
    input  wire logic               res_take,
    output res_t                    res
);

    localparam int unsigned VAL_W  = (ITEM_WIDTH < VALUE_W) ? ITEM_WIDTH : VALUE_W;
    localparam int unsigned CNT_W  = $clog2(SET_DEPTH + 1);
    localparam int unsigned IDX_W  = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             pend_reg, pend_next;
    logic             action_reg;
    logic [VAL_W-1:0] value_reg;
    logic [VAL_W-1:0] rd_data_reg;
    res_t             res_reg, res_next;

    logic [VAL_W-1:0] mem [SET_DEPTH];

    logic                   issue;
    logic                   hit;
    logic                   decide;
    logic                   can_store;
    logic                   wr_en;
    logic                   rd_en;
    logic                   reject;
    logic [CNT_W+COUNT_W-1:0] count_ext;

    assign issue     = idx_reg < count_reg;
    assign hit       = pend_reg && (rd_data_reg == value_reg);
    assign decide    = (state_reg == ST_SCAN) && (hit || (!issue && !pend_reg));
    assign can_store = count_reg < CNT_W'(SET_DEPTH);
    assign wr_en     = decide && !hit && action_reg && can_store;
    assign reject    = decide && !hit && action_reg && !can_store;
    assign rd_en     = (state_reg == ST_SCAN) && issue;
    assign count_ext = {{COUNT_W{1'b0}}, count_next};

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[count_reg[IDX_W-1:0]] <= value_reg;
        end
        if (rd_en) begin
            rd_data_reg <= mem[idx_reg[IDX_W-1:0]];
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pend_next  = pend_reg;
        count_next = count_reg + CNT_W'(wr_en);
        res_next   = res_reg;
        case (state_reg)
            ST_IDLE:
            begin
                idx_next  = '0;
                pend_next = 1'b0;
                if (in_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                idx_next  = idx_reg + CNT_W'(issue);
                pend_next = issue;
                if (decide) begin
                    state_next           = ST_DONE;
                    res_next.was_present = hit;
                    res_next.stored_now  = wr_en;
                    res_next.full_reject = reject;
                    res_next.item_count  = count_ext[COUNT_W-1:0];
                end
            end
            ST_DONE:
            begin
                if (res_take) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk) begin
        res_reg <= res_next;
        if (in_valid && in_ready) begin
            action_reg <= in_action;
            value_reg  <= in_value[VAL_W-1:0];
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(SET_DEPTH))
        else $error("slot count above capacity");

    a_present_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.was_present) |-> (!res.stored_now && !res.full_reject))
        else $error("present item also stored or rejected");

    a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.full_reject) |-> (count_reg == CNT_W'(SET_DEPTH)))
        else $error("reject while set not full");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken during scan");

endmodule

`default_nettype wire

// ===== hdl/unique_item_set.sv =====
// unique_item_set: top level, stream ports and result output register.
// Depends on uis_pkg and uis_scan.
//
// Usage:
//   Input beats carry a value and an action (test or add). Output beats carry
//   was_present, stored_now, full_reject and the slot count after the item.
//   One output beat per input beat, in order.
//   Scan: an item is scanned against the occupied slots, one compare per
//   cycle from the single-port slot memory (registered read). A miss loads
//   the output register after every occupied slot is compared; a hit ends
//   earlier. The output beat can be taken at the next edge. The next input
//   beat can be accepted only after the previous result has left the scanner.
//   The scanner holds one item; s_axis_tready is high while the scanner idles.
//   The output register frees the scanner as soon as a result is loaded, so
//   the next item is accepted while the previous result waits.
//   If the receiver stalls with a result still held, the scanner holds its
//   finished result and accepts nothing new until it can be handed over.
//   Reset empties the set (count 0) and drops any pending beat; slot
//   contents are not cleared, since only occupied slots are ever read.
`default_nettype none

module unique_item_set
    import uis_pkg::*;
#(
    parameter int unsigned SET_DEPTH  = 16,
    parameter int unsigned ITEM_WIDTH = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [VALUE_W-1:0] s_axis_tdata,   // [31:0] item_value
    input  wire logic [0:0]         s_axis_tuser,   // [0] action
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [RES_W-1:0]        m_axis_tdata    // [0] was_present, [1] stored_now,
                                                    // [2] full_reject, [7:3] item_count
);

    logic             res_valid;
    logic             res_take;
    res_t             res;
    logic             out_valid_reg, out_valid_next;
    res_t             out_reg;

    uis_scan #(
        .SET_DEPTH  (SET_DEPTH),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_action (s_axis_tuser[0]),
        .in_value  (s_axis_tdata),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    assign res_take = res_valid && (!out_valid_reg || m_axis_tready);

    always_comb begin
        out_valid_next = out_valid_reg;
        if (res_take) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (res_take) begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

endmodule

`default_nettype wire
